// ===== hw/rtl/usg_pkg.sv =====
// usg_pkg: shared widths, status codes, register indexes and types for the
// Ulam sequence generator. No dependencies; imported by usg_seq and the top.
package usg_pkg;

	localparam int SEED_W   = 15;
	localparam int LIMIT_W  = 11;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 2;
	localparam int VAL_W    = 16;
	localparam int IDX_W    = 10;
	localparam int STAT_W   = 2;
	localparam int SUM_W    = 17;
	localparam int CNT_W    = 2;

	localparam int MAX_TERMS_DEF   = 1024;
	localparam int STORE_DEPTH_DEF = 65536;
	localparam int SCAN_LIMIT      = 65536;

	localparam logic [SEED_W-1:0]  SEED_ONE_RST   = 15'd1;
	localparam logic [SEED_W-1:0]  SEED_TWO_RST   = 15'd2;
	localparam logic [LIMIT_W-1:0] TERM_LIMIT_RST = 11'd1024;
	localparam int                 LIMIT_MIN      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SEEDS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_LIMIT     = 2'd3;

	localparam logic [CNT_W-1:0] CNT_ONCE = 2'd1;
	localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

	typedef struct packed {
		logic [SEED_W-1:0]  seed_one;
		logic [SEED_W-1:0]  seed_two;
		logic [LIMIT_W-1:0] term_limit;
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [IDX_W-1:0]  index;
		logic [STAT_W-1:0] status;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c >= CNT_SAT) ? CNT_SAT : c + CNT_ONCE;
	endfunction

endpackage

// ===== hw/rtl/usg_ram.sv =====
// usg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module usg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/usg_seq.sv =====
// usg_seq: sequencer with term store and sum-count store; clears, scans and
// updates counts one memory step per cycle. Depends on usg_pkg and usg_ram.
module usg_seq #(
	parameter int MAX_TERMS   = usg_pkg::MAX_TERMS_DEF,
	parameter int STORE_DEPTH = usg_pkg::STORE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  usg_pkg::cfg_t cfg,
	input  logic          start,
	input  logic          restart,
	output logic          busy,
	output usg_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ack
);
	import usg_pkg::*;

	localparam int TW       = $clog2(MAX_TERMS);
	localparam int CW       = $clog2(MAX_TERMS + 1);
	localparam int AW       = $clog2(STORE_DEPTH);
	localparam int SCAN_END = (STORE_DEPTH < SCAN_LIMIT) ? STORE_DEPTH : SCAN_LIMIT;
	localparam int CMPW     = (AW + 1 > SUM_W) ? AW + 1 : SUM_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_SEED = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    terms_q;
	logic [SUM_W-1:0] scan_q;
	logic [VAL_W-1:0] v_q;
	logic [TW-1:0]    i_q;
	logic             iss_q;
	logic             t_v_s1;
	logic             c_v_s2;
	logic [AW-1:0]    s_s2;
	logic             chk_v_s1;
	logic [SUM_W-1:0] chk_addr_s1;
	logic [AW-1:0]    clr_q;
	res_t             res_q;

	logic             t_we;
	logic [TW-1:0]    t_waddr;
	logic [VAL_W-1:0] t_wdata;
	logic [VAL_W-1:0] t_rdata;
	logic             c_we;
	logic [AW-1:0]    c_waddr;
	logic [CNT_W-1:0] c_wdata;
	logic [AW-1:0]    c_raddr;
	logic [CNT_W-1:0] c_rdata;

	logic [SUM_W-1:0] tl_w;
	logic [SUM_W-1:0] lim_w;
	logic [SUM_W-1:0] terms_w;
	logic [SUM_W-1:0] sum;
	logic             sum_in;
	logic             last_i;
	logic             scan_lt;
	logic             hit;
	logic             upd_done;
	logic             bad_seeds;
	logic [SEED_W-1:0] seed_lo;
	logic [SEED_W-1:0] seed_hi;

	always_comb begin
		tl_w = SUM_W'(cfg.term_limit);
		if (tl_w < SUM_W'(LIMIT_MIN)) begin
			lim_w = SUM_W'(LIMIT_MIN);
		end else if (tl_w > SUM_W'(MAX_TERMS)) begin
			lim_w = SUM_W'(MAX_TERMS);
		end else begin
			lim_w = tl_w;
		end
	end

	assign terms_w   = SUM_W'(terms_q);
	assign sum       = SUM_W'(v_q) + SUM_W'(t_rdata);
	assign sum_in    = CMPW'(sum) < CMPW'(STORE_DEPTH);
	assign last_i    = (CW'(i_q) + CW'(1)) == terms_q;
	assign scan_lt   = scan_q < SUM_W'(SCAN_END);
	assign hit       = chk_v_s1 && (c_rdata == CNT_ONCE);
	assign upd_done  = !iss_q && !t_v_s1 && !c_v_s2;
	assign bad_seeds = (cfg.seed_one == '0) || (cfg.seed_two == '0)
		|| (cfg.seed_one == cfg.seed_two);
	assign seed_lo   = (cfg.seed_one < cfg.seed_two) ? cfg.seed_one : cfg.seed_two;
	assign seed_hi   = (cfg.seed_one < cfg.seed_two) ? cfg.seed_two : cfg.seed_one;

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_OUT;
	assign res       = res_q;

	// term store port
	always_comb begin
		t_we    = 1'b0;
		t_waddr = TW'(terms_q);
		t_wdata = v_q;
		if (state_q == S_SEED) begin
			t_we    = !bad_seeds;
			t_waddr = '0;
			t_wdata = VAL_W'(seed_lo);
		end else if (state_q == S_UPD) begin
			t_we    = upd_done;
		end
	end

	// count store port
	always_comb begin
		c_we    = 1'b0;
		c_waddr = s_s2;
		c_wdata = sat_inc(c_rdata);
		c_raddr = AW'(sum);
		if (state_q == S_CLR) begin
			c_we    = 1'b1;
			c_waddr = clr_q;
			c_wdata = '0;
		end else if (state_q == S_UPD) begin
			c_we    = c_v_s2;
		end
		if (state_q == S_SCAN) begin
			c_raddr = AW'(scan_q);
		end
	end

	usg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_TERMS)) u_term_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (i_q),
		.rdata (t_rdata)
	);

	usg_ram #(.WIDTH(CNT_W), .DEPTH(STORE_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			terms_q  <= '0;
			scan_q   <= '0;
			iss_q    <= 1'b0;
			t_v_s1   <= 1'b0;
			c_v_s2   <= 1'b0;
			chk_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (restart || terms_q == '0) begin
							state_q <= S_CLR;
						end else if (terms_w >= lim_w) begin
							state_q <= S_OUT;
						end else if (terms_q == CW'(1)) begin
							state_q <= S_UPD;
							iss_q   <= 1'b1;
						end else begin
							state_q  <= S_SCAN;
							chk_v_s1 <= 1'b0;
						end
					end
				end
				S_CLR: begin
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					state_q <= S_OUT;
					scan_q  <= '0;
					terms_q <= bad_seeds ? CW'(0) : CW'(1);
				end
				S_SCAN: begin
					if (hit) begin
						scan_q   <= chk_addr_s1 + SUM_W'(1);
						chk_v_s1 <= 1'b0;
						iss_q    <= 1'b1;
						state_q  <= S_UPD;
					end else if (!scan_lt && !chk_v_s1) begin
						scan_q  <= SUM_W'(SCAN_END);
						state_q <= S_OUT;
					end else begin
						chk_v_s1 <= scan_lt;
						if (scan_lt) begin
							scan_q <= scan_q + SUM_W'(1);
						end
					end
				end
				S_UPD: begin
					t_v_s1 <= iss_q;
					if (iss_q && last_i) begin
						iss_q <= 1'b0;
					end
					c_v_s2 <= t_v_s1 && sum_in;
					if (upd_done) begin
						terms_q <= terms_q + CW'(1);
						scan_q  <= SUM_W'(v_q) + SUM_W'(1);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				clr_q <= '0;
				i_q   <= '0;
				res_q <= '{value: '0, index: '0, status: STAT_LIMIT};
			end
			S_CLR: begin
				clr_q <= clr_q + AW'(1);
			end
			S_SEED: begin
				v_q <= VAL_W'(seed_hi);
				if (bad_seeds) begin
					res_q <= '{value: '0, index: '0, status: STAT_BAD_SEEDS};
				end else begin
					res_q <= '{value: VAL_W'(seed_lo), index: '0, status: STAT_OK};
				end
			end
			S_SCAN: begin
				i_q         <= '0;
				chk_addr_s1 <= scan_q;
				res_q       <= '{value: '0, index: '0, status: STAT_OVERFLOW};
				if (hit) begin
					v_q <= chk_addr_s1[VAL_W-1:0];
				end
			end
			S_UPD: begin
				if (iss_q && !last_i) begin
					i_q <= i_q + TW'(1);
				end
				s_s2  <= AW'(sum);
				res_q <= '{value: v_q, index: IDX_W'(terms_q), status: STAT_OK};
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/ulam_sequence_generator_top.sv =====
// ulam_sequence_generator_top: config registers, output word register and the
// sequencer. Depends on usg_pkg, usg_seq and usg_ram.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    restart
//   out      out  out_valid/out_stall  term_value, term_index, status
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// Restart (or any word while no term is made) clears the whole count store, then
// writes the first seed term. Term limit reached: straight to the result word.
// Second term: a count update pass, independent of MAX_TERMS. Later terms: a scan
// for the next candidate, then count updates over all terms made, then the result.
// in_stall is high from acceptance until the result word is in the output
// register; a stalled output holds the sequencer until the register frees.
module ulam_sequence_generator_top #(
	parameter int MAX_TERMS   = usg_pkg::MAX_TERMS_DEF,
	parameter int STORE_DEPTH = usg_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [usg_pkg::VAL_W-1:0]       term_value,
	output logic [usg_pkg::IDX_W-1:0]       term_index,
	output logic [usg_pkg::STAT_W-1:0]      status,
	input  logic                            cfg_we,
	input  logic [usg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [usg_pkg::CFG_W-1:0]       cfg_data
);
	import usg_pkg::*;

	cfg_t cfg_q;
	res_t res;
	logic busy;
	logic res_valid;
	logic res_ack;
	logic out_valid_q;
	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed_one   <= SEED_ONE_RST;
			cfg_q.seed_two   <= SEED_TWO_RST;
			cfg_q.term_limit <= TERM_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED_ONE:   cfg_q.seed_one   <= SEED_W'(cfg_data);
				CFG_SEED_TWO:   cfg_q.seed_two   <= SEED_W'(cfg_data);
				CFG_TERM_LIMIT: cfg_q.term_limit <= LIMIT_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign in_stall = busy;

	usg_seq #(.MAX_TERMS(MAX_TERMS), .STORE_DEPTH(STORE_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid && !in_stall),
		.restart   (restart),
		.busy      (busy),
		.res       (res),
		.res_valid (res_valid),
		.res_ack   (res_ack)
	);

	assign res_ack = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign term_value = out_q.value;
	assign term_index = out_q.index;
	assign status     = out_q.status;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> term_value == '0 && term_index == '0)
		else $error("error word carries a term");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_OK |-> term_value != '0)
		else $error("zero term reported ok");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !res_valid)
		else $error("taking input with a result pending");

	a_ack_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_ack |=> out_valid && !busy)
		else $error("result word lost");

endmodule
